>>> rtl/mppc_pkg.sv
// Package for the motor PWM panel controller: operation codes, result
// record, seven-segment table and small arithmetic helpers.
// No dependencies.
package mppc_pkg;

   // PWM counter runs 0 .. PWM_PERIOD-1 and wraps.
   localparam int PWM_PERIOD = 255;
   localparam int PWM_CNT_W  = (PWM_PERIOD > 2) ? $clog2(PWM_PERIOD) : 1;
   localparam logic [PWM_CNT_W:0] PWM_WRAP = (PWM_CNT_W + 1)'(PWM_PERIOD);

   // Number of scanned display digits (units, tens, hundreds).
   localparam int DIGIT_COUNT = 3;
   localparam logic [1:0] SCAN_LAST = 2'(DIGIT_COUNT - 1);

   // Direction latch codes: bit0 dir_a, bit1 dir_b, bit2 green, bit3 red.
   localparam logic [3:0] DIR_RIGHT = 4'b0101;
   localparam logic [3:0] DIR_LEFT  = 4'b1010;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_SAMPLE    = 2'd0,
      OP_PWM_TICK  = 2'd1,
      OP_SCAN_TICK = 2'd2
   } op_type;

   // One response item.
   typedef struct packed {
      logic       pwm_low_side;
      logic       pwm_high_side;
      logic       dir_a;
      logic       dir_b;
      logic       led_green;
      logic       led_red;
      logic [6:0] segment_lines;
      logic [2:0] digit_select;
   } rsp_type;

   // Lit-segment patterns for decimal digits, bit0 = a through bit6 = g.
   localparam logic [6:0] SEG_PATTERN [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // Shown value 100 - duty*100/255. The divide by 255 uses the exact
   // 16-bit identity x/255 = (x + (x >> 8) + 1) >> 8.
   function automatic logic [6:0] shown_for_duty(input logic [7:0] duty);
      logic [14:0] scaled;
      logic [16:0] sum;
      logic [6:0]  quot;
      scaled = 15'(duty) * 15'd100;
      sum    = 17'(scaled) + 17'(scaled >> 8) + 17'd1;
      quot   = sum[14:8];
      return 7'd100 - quot;
   endfunction

   // Decimal digit of a value below 128 at a scan position. The divide by
   // ten is a multiply by 205 and a shift, exact for this range.
   function automatic logic [3:0] digit_at(input logic [6:0] value,
                                           input logic [1:0] pos);
      logic [14:0] prod;
      logic [3:0]  tens_q;
      logic [6:0]  units;
      logic [3:0]  result;
      prod   = 15'(value) * 15'd205;
      tens_q = prod[14:11];
      units  = value - 7'(tens_q) * 7'd10;
      case (pos)
         2'd0:    result = units[3:0];
         2'd1:    result = (tens_q >= 4'd10) ? (tens_q - 4'd10) : tens_q;
         default: result = (value >= 7'd100) ? 4'd1 : 4'd0;
      endcase
      return result;
   endfunction

endpackage

>>> rtl/mppc_req_if.sv
// Request channel of the motor PWM panel controller: valid, ready, payload.
// Depends on nothing.
interface mppc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [11:0] adc_sample;
   logic        button_right;
   logic        button_left;

   modport source (output valid, op, adc_sample, button_right, button_left,
                   input ready);
   modport sink   (input valid, op, adc_sample, button_right, button_left,
                   output ready);
endinterface

>>> rtl/mppc_rsp_if.sv
// Response channel of the motor PWM panel controller: valid, ready, payload.
// Depends on nothing.
interface mppc_rsp_if;
   logic       valid;
   logic       ready;
   logic       pwm_low_side;
   logic       pwm_high_side;
   logic       dir_a;
   logic       dir_b;
   logic       led_green;
   logic       led_red;
   logic [6:0] segment_lines;
   logic [2:0] digit_select;

   modport source (output valid, pwm_low_side, pwm_high_side, dir_a, dir_b,
                   led_green, led_red, segment_lines, digit_select,
                   input ready);
   modport sink   (input valid, pwm_low_side, pwm_high_side, dir_a, dir_b,
                   led_green, led_red, segment_lines, digit_select,
                   output ready);
endinterface

>>> rtl/motor_pwm_panel_controller.sv
// Motor PWM panel controller top level: state update, response register
// and skid stage. Depends on mppc_pkg, mppc_req_if and mppc_rsp_if.
//
// Usage:
//   Each request on req_chan is one of: a sample (potentiometer reading and
//   two buttons), a PWM tick, or a display scan tick. Every request produces
//   exactly one response on rsp_chan carrying the complementary PWM drive,
//   the latched direction lines and LEDs, and the held seven-segment lines
//   and one-hot digit select after that request has taken effect.
//   Each response is written to the response register, or to the skid
//   stage if the receiver stalls. Throughput is one request per cycle
//   while the receiver keeps up; the state update, divide by 255 scale and
//   digit decode sit between request handshake and response register.
//   When the receiver stalls, one further request is taken into a skid
//   stage; req_chan.ready then drops until the response register drains.
//   Synchronous reset clears the PWM counter, duty, shown value, scan
//   position, direction latch and held display lines, and empties the
//   response and skid registers. Until a sample sets a nonzero duty,
//   responses show the low side off and the high side on.
module motor_pwm_panel_controller (
   input logic        clock,
   input logic        reset,
   mppc_req_if.sink   req_chan,
   mppc_rsp_if.source rsp_chan
);

   // Block state.
   logic [mppc_pkg::PWM_CNT_W-1:0] pwm_count_ff, pwm_count_in;
   logic [7:0] duty_level_ff, duty_level_in;
   logic [6:0] shown_value_ff, shown_value_in;
   logic [1:0] scan_position_ff, scan_position_in;
   logic [3:0] dir_leds_ff, dir_leds_in;
   logic [6:0] held_segments_ff, held_segments_in;
   logic [2:0] held_select_ff, held_select_in;

   // Response register and skid stage.
   logic              rsp_valid_ff, rsp_valid_in;
   mppc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              skid_valid_ff, skid_valid_in;
   mppc_pkg::rsp_type skid_data_ff, skid_data_in;

   logic              req_accept;
   logic              rsp_take;
   mppc_pkg::rsp_type new_rsp;

   assign req_chan.ready = !skid_valid_ff;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;

   // Next state for the accepted request and the response it produces.
   always_comb begin
      logic [mppc_pkg::PWM_CNT_W:0] count_step;
      logic [3:0] digit;
      pwm_count_in     = pwm_count_ff;
      duty_level_in    = duty_level_ff;
      shown_value_in   = shown_value_ff;
      scan_position_in = scan_position_ff;
      dir_leds_in      = dir_leds_ff;
      held_segments_in = held_segments_ff;
      held_select_in   = held_select_ff;
      count_step       = (mppc_pkg::PWM_CNT_W + 1)'(pwm_count_ff) + 1'b1;
      digit            = mppc_pkg::digit_at(shown_value_ff, scan_position_ff);
      if (req_accept) begin
         case (req_chan.op)
            mppc_pkg::OP_SAMPLE: begin
               duty_level_in  = req_chan.adc_sample[11:4];
               shown_value_in = mppc_pkg::shown_for_duty(req_chan.adc_sample[11:4]);
               if (req_chan.button_right) begin
                  dir_leds_in = mppc_pkg::DIR_RIGHT;
               end else if (req_chan.button_left) begin
                  dir_leds_in = mppc_pkg::DIR_LEFT;
               end
            end
            mppc_pkg::OP_PWM_TICK: begin
               if (count_step >= mppc_pkg::PWM_WRAP) begin
                  pwm_count_in = '0;
               end else begin
                  pwm_count_in = count_step[mppc_pkg::PWM_CNT_W-1:0];
               end
            end
            mppc_pkg::OP_SCAN_TICK: begin
               held_segments_in = ~mppc_pkg::SEG_PATTERN[digit];
               held_select_in   = 3'(3'b001 << scan_position_ff);
               if (scan_position_ff == mppc_pkg::SCAN_LAST) begin
                  scan_position_in = 2'd0;
               end else begin
                  scan_position_in = scan_position_ff + 2'd1;
               end
            end
            default: begin
               // Unused code: state holds, response reports current outputs.
            end
         endcase
      end

      new_rsp.pwm_low_side  = 9'(pwm_count_in) < 9'(duty_level_in);
      new_rsp.pwm_high_side = !new_rsp.pwm_low_side;
      new_rsp.dir_a         = dir_leds_in[0];
      new_rsp.dir_b         = dir_leds_in[1];
      new_rsp.led_green     = dir_leds_in[2];
      new_rsp.led_red       = dir_leds_in[3];
      new_rsp.segment_lines = held_segments_in;
      new_rsp.digit_select  = held_select_in;
   end

   // Response register with one skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = new_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_rsp;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_count_ff     <= '0;
         duty_level_ff    <= '0;
         shown_value_ff   <= '0;
         scan_position_ff <= '0;
         dir_leds_ff      <= '0;
         held_segments_ff <= '0;
         held_select_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         pwm_count_ff     <= pwm_count_in;
         duty_level_ff    <= duty_level_in;
         shown_value_ff   <= shown_value_in;
         scan_position_ff <= scan_position_in;
         dir_leds_ff      <= dir_leds_in;
         held_segments_ff <= held_segments_in;
         held_select_ff   <= held_select_in;
         rsp_valid_ff     <= rsp_valid_in;
         skid_valid_ff    <= skid_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Drive the response channel.
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_low_side  = rsp_data_ff.pwm_low_side;
   assign rsp_chan.pwm_high_side = rsp_data_ff.pwm_high_side;
   assign rsp_chan.dir_a         = rsp_data_ff.dir_a;
   assign rsp_chan.dir_b         = rsp_data_ff.dir_b;
   assign rsp_chan.led_green     = rsp_data_ff.led_green;
   assign rsp_chan.led_red       = rsp_data_ff.led_red;
   assign rsp_chan.segment_lines = rsp_data_ff.segment_lines;
   assign rsp_chan.digit_select  = rsp_data_ff.digit_select;

   // The skid entry is only ever occupied behind a full response register.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds data while response register is empty");

   // The PWM counter never reaches the period.
   a_pwm_count_range: assert property (@(posedge clock) disable iff (reset)
      (mppc_pkg::PWM_CNT_W + 1)'(pwm_count_ff) < mppc_pkg::PWM_WRAP)
      else $error("PWM counter outside its period");

   // The scan position stays within the digit count.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      scan_position_ff <= mppc_pkg::SCAN_LAST)
      else $error("scan position past the last digit");

   // The shown value never exceeds one hundred.
   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      shown_value_ff <= 7'd100)
      else $error("shown value above one hundred");

   // The direction latch only ever holds cleared, right or left.
   a_dir_codes: assert property (@(posedge clock) disable iff (reset)
      dir_leds_ff == 4'b0000 || dir_leds_ff == mppc_pkg::DIR_RIGHT ||
      dir_leds_ff == mppc_pkg::DIR_LEFT)
      else $error("direction latch holds an invalid pattern");

   // A request taken while the skid is empty always lands in a register.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule

>>> sim/motor_pwm_panel_controller_test.sv
// Self-checking testbench for the motor PWM panel controller: it drives random and directed
// requests, predicts every response and compares it field by field with the block's output.
// Depends on mppc_pkg, mppc_req_if, mppc_rsp_if and motor_pwm_panel_controller.
module motor_pwm_panel_controller_test;

   // Op code 3 has no meaning; the block must leave its state alone.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Cycles without any handshake before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_COUNT = 1750;
   localparam int TAIL_COUNT = 150;
   localparam int HOLD_CYCLES = 90;
   localparam int HOLD_AFTER = 400;
   localparam int SETTLE_CYCLES = 16;

   // Lit segments per decimal digit, bit0 = a through bit6 = g.
   localparam logic [6:0] DIGIT_GLYPH [10] = '{
      7'b0111111, 7'b0000110, 7'b1011011, 7'b1001111, 7'b1100110,
      7'b1101101, 7'b1111101, 7'b0000111, 7'b1111111, 7'b1101111
   };

   typedef struct {
      logic [1:0]  op;
      logic [11:0] adc_sample;
      logic        button_right;
      logic        button_left;
   } panel_request;

   logic clock;
   logic reset;

   mppc_req_if req_chan ();
   mppc_rsp_if rsp_chan ();

   motor_pwm_panel_controller DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Panel state as the testbench expects it.
   logic [7:0] pwm_count;
   logic [7:0] duty_level;
   logic [6:0] shown_value;
   logic [1:0] scan_position;
   logic [3:0] dir_leds;
   logic [6:0] held_segments;
   logic [2:0] held_select;

   panel_request      pending_requests [$];
   mppc_pkg::rsp_type expected_panels [$];
   panel_request      on_wire;

   int mismatches;
   int requests_accepted;
   int responses_seen;
   int send_gap;
   int recv_stall;
   int hold_left;
   bit hold_done;
   bit quiet_tail;
   int idle_cycles;

   always #4 clock = ~clock;

   // Advance the expected panel state by one request and return the response it causes.
   function automatic mppc_pkg::rsp_type predict_panel(input panel_request rq);
      mppc_pkg::rsp_type res;
      int                value;
      int                digit;
      logic [1:0]        pos;
      if (rq.op == mppc_pkg::OP_SAMPLE) begin
         duty_level  = rq.adc_sample[11:4];
         shown_value = 7'(100 - (int'(duty_level) * 100) / 255);
         if (rq.button_right) begin
            dir_leds = mppc_pkg::DIR_RIGHT;
         end else if (rq.button_left) begin
            dir_leds = mppc_pkg::DIR_LEFT;
         end
      end else if (rq.op == mppc_pkg::OP_PWM_TICK) begin
         if (int'(pwm_count) + 1 >= mppc_pkg::PWM_PERIOD) begin
            pwm_count = 8'd0;
         end else begin
            pwm_count = pwm_count + 8'd1;
         end
      end else if (rq.op == mppc_pkg::OP_SCAN_TICK) begin
         value = int'(shown_value);
         pos   = scan_position;
         case (pos)
            2'd0:    digit = value % 10;
            2'd1:    digit = (value / 10) % 10;
            default: digit = (value / 100) % 10;
         endcase
         if (pos > 2'd2) begin
            pos = 2'd2;
         end
         held_segments = ~DIGIT_GLYPH[digit];
         held_select   = 3'(1 << pos);
         scan_position = 2'((int'(scan_position) + 1) % mppc_pkg::DIGIT_COUNT);
      end
      res.pwm_low_side  = (pwm_count < duty_level);
      res.pwm_high_side = ~res.pwm_low_side;
      res.dir_a         = dir_leds[0];
      res.dir_b         = dir_leds[1];
      res.led_green     = dir_leds[2];
      res.led_red       = dir_leds[3];
      res.segment_lines = held_segments;
      res.digit_select  = held_select;
      return res;
   endfunction

   task automatic queue_request(input logic [1:0] op, input logic [11:0] adc,
                                input logic right, input logic left);
      panel_request rq;
      rq.op           = op;
      rq.adc_sample   = adc;
      rq.button_right = right;
      rq.button_left  = left;
      pending_requests.push_back(rq);
   endtask

   // Pick a sample value, leaning on the ends of the range now and then.
   function automatic logic [11:0] pick_sample();
      logic [11:0] adc;
      case ($urandom_range(0, 11))
         0:       adc = 12'd0;
         1:       adc = 12'hFFF;
         2:       adc = 12'h00F;
         3:       adc = 12'h010;
         default: adc = 12'($urandom);
      endcase
      return adc;
   endfunction

   // Every fourth block of 128 requests, and the quiet tail, start no new random idling on either side.
   function automatic bit calm_phase();
      return quiet_tail || ((requests_accepted / 128) % 4 == 3);
   endfunction

   // Request driver: offers queued requests and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            expected_panels.push_back(predict_panel(on_wire));
            requests_accepted++;
         end
         quiet_tail = (pending_requests.size() < TAIL_COUNT);
         if (req_chan.valid && !req_chan.ready) begin
            // Hold the offered request until it is taken.
         end else begin
            if (send_gap == 0 && !calm_phase() && hold_left == 0 &&
                $urandom_range(0, 99) < 10) begin
               send_gap = $urandom_range(1, 13);
            end
            if (send_gap > 0) begin
               send_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               on_wire = pending_requests.pop_front();
               req_chan.op           <= on_wire.op;
               req_chan.adc_sample   <= on_wire.adc_sample;
               req_chan.button_right <= on_wire.button_right;
               req_chan.button_left  <= on_wire.button_left;
               req_chan.valid        <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each accepted response and throttles ready.
   always @(posedge clock) begin
      mppc_pkg::rsp_type got;
      mppc_pkg::rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.pwm_low_side  = rsp_chan.pwm_low_side;
            got.pwm_high_side = rsp_chan.pwm_high_side;
            got.dir_a         = rsp_chan.dir_a;
            got.dir_b         = rsp_chan.dir_b;
            got.led_green     = rsp_chan.led_green;
            got.led_red       = rsp_chan.led_red;
            got.segment_lines = rsp_chan.segment_lines;
            got.digit_select  = rsp_chan.digit_select;
            responses_seen++;
            if (expected_panels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response %0d arrived with nothing expected: %p",
                           responses_seen, got);
               end
            end else begin
               want = expected_panels.pop_front();
               if (got.pwm_low_side !== want.pwm_low_side ||
                   got.pwm_high_side !== want.pwm_high_side ||
                   got.dir_a !== want.dir_a || got.dir_b !== want.dir_b ||
                   got.led_green !== want.led_green || got.led_red !== want.led_red ||
                   got.segment_lines !== want.segment_lines ||
                   got.digit_select !== want.digit_select) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response %0d mismatch: expected %p, actual %p",
                              responses_seen, want, got);
                  end
               end
            end
         end
         // One long hold-off lets the block fill and stall its request side.
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (recv_stall == 0 && !calm_phase() && $urandom_range(0, 99) < 10) begin
               recv_stall = $urandom_range(1, 13);
            end
            if (recv_stall > 0) begin
               recv_stall--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("motor_pwm_panel_controller_test NOT OK");
            $finish;
         end
      end
   end

   initial begin
      int r;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.op           = mppc_pkg::OP_SAMPLE;
      req_chan.adc_sample   = 12'd0;
      req_chan.button_right = 1'b0;
      req_chan.button_left  = 1'b0;
      rsp_chan.ready        = 1'b0;
      pwm_count     = 8'd0;
      duty_level    = 8'd0;
      shown_value   = 7'd0;
      scan_position = 2'd0;
      dir_leds      = 4'd0;
      held_segments = 7'd0;
      held_select   = 3'd0;
      mismatches        = 0;
      requests_accepted = 0;
      responses_seen    = 0;
      hold_left         = 0;
      hold_done         = 1'b0;
      quiet_tail        = 1'b0;
      idle_cycles       = 0;

      // Directed part: reset outputs, the unused op, both buttons, latch hold,
      // scan through all digits and its wrap, and the ends of the sample range.
      queue_request(OP_UNUSED, 12'hFFF, 1'b1, 1'b1);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_PWM_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SAMPLE, 12'hFFF, 1'b1, 1'b1);
      queue_request(mppc_pkg::OP_PWM_TICK, 12'hABC, 1'b1, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SAMPLE, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'hFFF, 1'b1, 1'b1);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SAMPLE, 12'h00F, 1'b0, 1'b1);
      queue_request(mppc_pkg::OP_PWM_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SAMPLE, 12'h010, 1'b0, 1'b0);
      queue_request(OP_UNUSED, 12'h555, 1'b0, 1'b1);
      queue_request(mppc_pkg::OP_SAMPLE, 12'h7FF, 1'b1, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_SAMPLE, 12'hFF0, 1'b0, 1'b1);
      queue_request(mppc_pkg::OP_SCAN_TICK, 12'h000, 1'b0, 1'b0);
      queue_request(mppc_pkg::OP_PWM_TICK, 12'hFFF, 1'b1, 1'b1);

      // Random part: mostly PWM ticks so the counter wraps several times.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            queue_request(mppc_pkg::OP_SAMPLE, pick_sample(), 1'($urandom), 1'($urandom));
         end else if (r < 68) begin
            queue_request(mppc_pkg::OP_PWM_TICK, 12'($urandom), 1'($urandom),
                          1'($urandom));
         end else if (r < 95) begin
            queue_request(mppc_pkg::OP_SCAN_TICK, 12'($urandom), 1'($urandom),
                          1'($urandom));
         end else begin
            queue_request(OP_UNUSED, 12'($urandom), 1'($urandom), 1'($urandom));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every response to arrive.
      while (pending_requests.size() != 0 || req_chan.valid || expected_panels.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_panels.size() == 0) begin
         $display("motor_pwm_panel_controller_test OK");
      end else begin
         $display("motor_pwm_panel_controller_test NOT OK");
      end
      $finish;
   end

endmodule
